[hw/rtl/sliding_window_sign_confluence_assert.svh]
// Assertion macros for the sign confluence block.
// Each macro checks one implication on the rising clock edge, with reset masking.
`ifndef SLIDING_WINDOW_SIGN_CONFLUENCE_ASSERT_SVH
`define SLIDING_WINDOW_SIGN_CONFLUENCE_ASSERT_SVH

// Same-cycle implication.
`define SWSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("swsc: same-cycle check failed");

// Next-cycle implication.
`define SWSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("swsc: next-cycle check failed");

`endif

[hw/rtl/swsc_pkg.sv]
`default_nettype none

package swsc_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int LEN_MIN    = 2;
    localparam int AW         = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int FRAC_W     = 15;
    localparam int DVD_W      = CNT_W + FRAC_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int THR_W      = 17;
    localparam int ONE_SHIFT  = 16;
    localparam int PROD_W     = THR_W + CNT_W;

    localparam int BIAS_W     = 32;
    localparam int SCORE_W    = 17;
    localparam int DIR_W      = 2;
    localparam int OBS_W      = 32;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CNT_W-1:0] WINDOW_LEN_RST = CNT_W'(16);
    localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(39322);

    typedef enum logic [1:0] {
        SIGN_ZERO  = 2'b00,
        SIGN_PLUS  = 2'b01,
        SIGN_MINUS = 2'b11
    } sign_t;

    localparam logic [DIR_W-1:0] DIR_BULL = 2'b01;
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_BEAR = 2'b11;

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_THRESHOLD  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_step;
        logic finish;
    } swsc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } swsc_stat_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_sign_confluence.sv]
// An accepted word passes the read, update, divide and finish states; the result word is registered at finish.
// A new word is taken only once the 22-step restoring divider and the finish of the last word are done.
// A finished result waits in the output register while the next word is taken.
// Reset: aresetn is synchronous and active low; it clears counts, ring fill and registers
// to their defaults (window 16, threshold 39322). Ring contents need no clearing.
`default_nettype none

`include "sliding_window_sign_confluence_assert.svh"

module sliding_window_sign_confluence import swsc_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    // Configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Input channel
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [S_DATA_W-1:0] s_tdata,  // [31:0] bias
    // Result channel
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [16:0] score, [18:17] direction,
                                          // [19] confluent, [20] fire,
                                          // [52:21] obs_total, [55:53] zero
);

    swsc_cmd_t  cmd;
    swsc_stat_t stat;

    assign pready = 1'b1;

    swsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swsc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Only one word is in flight at a time.
    `SWSC_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // The result register is loaded only when it is free.
    `SWSC_ASSERT_IMP(a_load_when_free, aclk, aresetn, cmd.finish, !m_tvalid || m_tready)
    // A load always presents a word on the next cycle.
    `SWSC_ASSERT_NXT(a_load_shows, aclk, aresetn, cmd.finish, m_tvalid)
    // A fire pulse is only ever given with confluence.
    `SWSC_ASSERT_IMP(a_fire_conf, aclk, aresetn, m_tvalid && m_tdata[20], m_tdata[19])

endmodule

`default_nettype wire

[hw/rtl/swsc_ctrl.sv]
`default_nettype none

module swsc_ctrl import swsc_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  swsc_stat_t stat,
    output swsc_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (stat.div_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_READ: begin
                cmd.read = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/swsc_dp.sv]
`default_nettype none

module swsc_dp import swsc_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    // Configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    // Input word
    input  wire  [S_DATA_W-1:0] s_tdata,
    // Result word
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    // Controller link
    input  swsc_cmd_t           cmd,
    output swsc_stat_t          stat
);

    logic [CNT_W-1:0]     window_len_reg;
    logic [THR_W-1:0]     threshold_reg;

    logic [1:0]           ring_mem [WINDOW_MAX];
    logic [1:0]           rd_data_reg;

    logic [1:0]           code_reg;
    logic [AW-1:0]        p_reg;
    logic [AW-1:0]        write_pos_reg;
    logic [CNT_W-1:0]     filled_reg;
    logic [CNT_W-1:0]     bull_reg;
    logic [CNT_W-1:0]     bear_reg;
    logic                 was_conf_reg;
    logic [OBS_W-1:0]     obs_reg;

    logic [CNT_W-1:0]     rem_reg;
    logic [SCORE_W-1:0]   quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    reg_idx_t             reg_idx;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     len;
    logic [AW-1:0]        p_next;
    logic [1:0]           code_next;
    logic [CNT_W-1:0]     p_plus1;
    logic                 old_valid;
    logic [CNT_W-1:0]     bull_next;
    logic [CNT_W-1:0]     bear_next;
    logic [CNT_W-1:0]     filled_next;
    logic [AW-1:0]        write_pos_next;
    logic [CNT_W-1:0]     diff;
    logic [DVD_W-1:0]     dividend;
    logic [DIV_CNT_W-1:0] bit_idx;
    logic [CNT_W:0]       rem_shift;
    logic                 q_bit;
    logic [CNT_W:0]       rem_trial;
    logic [PROD_W-1:0]    lhs;
    logic [PROD_W-1:0]    rhs;
    logic                 conf;
    logic                 fire;
    logic [SCORE_W-1:0]   score;
    logic [DIR_W-1:0]     dir;

    // Register file
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WINDOW_LEN: window_len_reg <= pwdata[CNT_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[THR_W-1:0];
                default:        window_len_reg <= window_len_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_LEN: prdata = APB_DW'(window_len_reg);
            REG_THRESHOLD:  prdata = APB_DW'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    // Effective ring length and write position
    always_comb begin
        if (window_len_reg < CNT_W'(LEN_MIN)) begin
            len = CNT_W'(LEN_MIN);
        end else if (window_len_reg > CNT_W'(WINDOW_MAX)) begin
            len = CNT_W'(WINDOW_MAX);
        end else begin
            len = window_len_reg;
        end
        p_next = ({1'b0, write_pos_reg} >= len) ? '0 : write_pos_reg;
        if (s_tdata == '0) begin
            code_next = SIGN_ZERO;
        end else if (s_tdata[S_DATA_W-1]) begin
            code_next = SIGN_MINUS;
        end else begin
            code_next = SIGN_PLUS;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg <= code_next;
            p_reg    <= p_next;
        end
    end

    // Sign ring; only entries below the fill count are counted when read back.
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_data_reg <= ring_mem[p_reg];
        end
        if (cmd.update) begin
            ring_mem[p_reg] <= code_reg;
        end
    end

    // Count update
    always_comb begin
        p_plus1   = CNT_W'({1'b0, p_reg}) + CNT_W'(1);
        old_valid = {1'b0, p_reg} < filled_reg;
        bull_next = bull_reg;
        bear_next = bear_reg;
        if (old_valid && rd_data_reg == SIGN_PLUS && bull_reg != '0) begin
            bull_next = bull_next - CNT_W'(1);
        end
        if (old_valid && rd_data_reg == SIGN_MINUS && bear_reg != '0) begin
            bear_next = bear_next - CNT_W'(1);
        end
        if (code_reg == SIGN_PLUS) begin
            bull_next = bull_next + CNT_W'(1);
        end
        if (code_reg == SIGN_MINUS) begin
            bear_next = bear_next + CNT_W'(1);
        end
        filled_next    = (p_plus1 > filled_reg) ? p_plus1 : filled_reg;
        write_pos_next = (p_plus1 >= len) ? '0 : p_plus1[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg <= '0;
            filled_reg    <= '0;
            bull_reg      <= '0;
            bear_reg      <= '0;
            obs_reg       <= '0;
        end else if (cmd.update) begin
            write_pos_reg <= write_pos_next;
            filled_reg    <= filled_next;
            bull_reg      <= bull_next;
            bear_reg      <= bear_next;
            obs_reg       <= obs_reg + OBS_W'(1);
        end
    end

    // Restoring divider: one quotient bit of diff*2^15/filled per cycle.
    assign diff      = (bull_reg >= bear_reg) ? bull_reg - bear_reg : bear_reg - bull_reg;
    assign dividend  = {diff, FRAC_W'(0)};
    assign bit_idx   = DIV_CNT_W'(DIV_STEPS - 1) - cnt_reg;
    assign rem_shift = {rem_reg, dividend[bit_idx]};
    assign q_bit     = rem_shift >= {1'b0, filled_reg};
    assign rem_trial = q_bit ? rem_shift - {1'b0, filled_reg} : rem_shift;

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            rem_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_trial[CNT_W-1:0];
            quot_reg <= {quot_reg[SCORE_W-2:0], q_bit};
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign stat.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Result assembly
    always_comb begin
        lhs   = PROD_W'({diff, ONE_SHIFT'(0)});
        rhs   = PROD_W'(threshold_reg) * PROD_W'(filled_reg);
        conf  = lhs >= rhs;
        fire  = conf && !was_conf_reg;
        score = (bear_reg > bull_reg) ? (~quot_reg + SCORE_W'(1)) : quot_reg;
        if (bull_reg >= bear_reg) begin
            dir = (bull_reg != '0) ? DIR_BULL : DIR_NONE;
        end else begin
            dir = DIR_BEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_conf_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            was_conf_reg <= conf;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= M_DATA_W'({obs_reg, fire, conf, dir, score});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[sim/sliding_window_sign_confluence_test.sv]
module sliding_window_sign_confluence_test;
    import swsc_pkg::*;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [DIR_W-1:0]   dir;
        logic               conf;
        logic               fire;
        logic [OBS_W-1:0]   obs;
    } verdict_t;

    class confluence_scoreboard;
        sign_t       ring [WINDOW_MAX];
        int unsigned win_reg;
        int unsigned thr_reg;
        int unsigned write_pos;
        int unsigned filled;
        int unsigned bulls;
        int unsigned bears;
        int unsigned obs;
        bit          was_conf;
        verdict_t    awaited [$];
        int unsigned mismatches;
        int unsigned noted;
        int unsigned checked;
        int unsigned fires;
        int unsigned conf_words;

        function new();
            foreach (ring[i]) ring[i] = SIGN_ZERO;
            win_reg    = WINDOW_LEN_RST;
            thr_reg    = THRESHOLD_RST;
            write_pos  = 0;
            filled     = 0;
            bulls      = 0;
            bears      = 0;
            obs        = 0;
            was_conf   = 1'b0;
            mismatches = 0;
            noted      = 0;
            checked    = 0;
            fires      = 0;
            conf_words = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
            if (idx == REG_WINDOW_LEN) begin
                win_reg = value[CNT_W-1:0];
            end else begin
                thr_reg = value[THR_W-1:0];
            end
        endfunction

        function void tally(sign_t s, bit add);
            case (s)
                SIGN_PLUS: begin
                    if (add) bulls++;
                    else if (bulls > 0) bulls--;
                end
                SIGN_MINUS: begin
                    if (add) bears++;
                    else if (bears > 0) bears--;
                end
                default: ;
            endcase
        endfunction

        // Works out the result word that one accepted bias word must produce.
        function void note_bias(logic [BIAS_W-1:0] bias);
            sign_t       s;
            int unsigned len;
            int unsigned p;
            int unsigned diff;
            int unsigned q;
            verdict_t    v;
            s = (bias == '0) ? SIGN_ZERO : (bias[BIAS_W-1] ? SIGN_MINUS : SIGN_PLUS);
            len = win_reg;
            if (len < LEN_MIN) len = LEN_MIN;
            if (len > WINDOW_MAX) len = WINDOW_MAX;
            obs = obs + 1;
            noted++;

            // A shrunken window may leave the write position past its end.
            p = write_pos;
            if (p >= len) p = 0;
            if (p < filled) tally(ring[p], 1'b0);
            ring[p] = s;
            tally(s, 1'b1);
            if (p + 1 > filled) filled = p + 1;
            write_pos = (p + 1 >= len) ? 0 : p + 1;

            diff = (bulls >= bears) ? bulls - bears : bears - bulls;
            q = (filled > 0) ? (diff * 32768) / filled : 0;
            v.score = (bears > bulls) ? SCORE_W'(0 - q) : SCORE_W'(q);
            if (bulls >= bears) begin
                v.dir = (bulls > 0) ? DIR_BULL : DIR_NONE;
            end else begin
                v.dir = DIR_BEAR;
            end
            v.conf = (64'(diff) << ONE_SHIFT) >= 64'(thr_reg) * 64'(filled);
            v.fire = v.conf && !was_conf;
            was_conf = v.conf;
            v.obs = OBS_W'(obs);
            awaited.push_back(v);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            verdict_t e;
            verdict_t got;
            got.score = word[16:0];
            got.dir   = word[18:17];
            got.conf  = word[19];
            got.fire  = word[20];
            got.obs   = word[52:21];
            checked++;
            if (got.conf) conf_words++;
            if (got.fire) fires++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result word %h arrived with none awaited", word);
                return;
            end
            e = awaited.pop_front();
            if (got.score !== e.score || got.dir !== e.dir || got.conf !== e.conf ||
                got.fire !== e.fire || got.obs !== e.obs) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected score %h dir %h conf %b fire %b obs %0d",
                             checked, e.score, e.dir, e.conf, e.fire, e.obs);
                    $display("result %0d:      got score %h dir %h conf %b fire %b obs %0d",
                             checked, got.score, got.dir, got.conf, got.fire, got.obs);
                end
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                mismatches += awaited.size();
                $display("%0d result words never arrived", awaited.size());
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [M_DATA_W-1:0] m_tdata;

    int unsigned send_idle = 31;
    int unsigned recv_idle = 51;
    int unsigned settings_used = 1;

    confluence_scoreboard sb = new();

    sliding_window_sign_confluence u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Result side: sample at the rising edge, choose the next ready at the falling edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #10_000_000;
        $display("[sliding_window_sign_confluence] ERROR");
        $finish;
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic program_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_bias(logic [BIAS_W-1:0] bias);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bias;
        do @(posedge aclk); while (!s_tready);
        sb.note_bias(bias);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    function automatic logic [BIAS_W-1:0] draw_bias(int unsigned bull_pct);
        int unsigned r;
        logic [30:0] mag;
        r   = $urandom_range(99);
        mag = 31'($urandom);
        if (r < 12) return '0;
        if ($urandom_range(99) < bull_pct) begin
            if (r < 17) return 32'h0000_0001;
            if (r < 22) return 32'h7FFF_FFFF;
            return {1'b0, (mag == '0) ? 31'd1 : mag};
        end
        if (r < 17) return 32'hFFFF_FFFF;
        if (r < 22) return 32'h8000_0000;
        return {1'b1, mag};
    endfunction

    // Runs of one leaning push the window into and out of confluence.
    task automatic run_batch(int unsigned count);
        int unsigned lean [5] = '{95, 80, 50, 20, 5};
        int unsigned bull_pct;
        int unsigned run_left;
        run_left = 0;
        bull_pct = 50;
        repeat (count) begin
            if (run_left == 0) begin
                bull_pct = lean[$urandom_range(4)];
                run_left = $urandom_range(4, 40);
            end
            run_left--;
            send_bias(draw_bias(bull_pct));
        end
    endtask

    initial begin
        int unsigned phase_win [9] = '{16, 2, 64, 0, 127, 7, 5, 0, 64};
        int unsigned phase_thr [9] = '{39322, 65536, 0, 32768, 70000, 131071, 20000, 0, 0};
        int unsigned w;
        int unsigned t;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: empty window, both signs, the extremes, then a bullish run.
        send_bias(32'h0000_0000);
        send_bias(32'h0000_0000);
        send_bias(32'h0000_0001);
        send_bias(32'hFFFF_FFFF);
        send_bias(32'h7FFF_FFFF);
        send_bias(32'h8000_0000);
        repeat (5) send_bias(32'h0000_0001);
        send_bias(32'h0000_0000);
        settle();

        // A threshold above one can never be reached.
        program_reg(REG_THRESHOLD, 32'd70000);
        send_bias(32'h0000_0001);
        send_bias(32'h0000_0001);
        settle();

        // Length below the minimum clamps to two, leaving the write position past the end.
        program_reg(REG_WINDOW_LEN, 32'd1);
        send_bias(32'h8000_0000);
        send_bias(32'h0000_0000);
        settle();

        // A zero threshold makes the next word confluent and fire.
        program_reg(REG_THRESHOLD, 32'd0);
        send_bias(32'h0000_0000);
        send_bias(32'h0000_0005);
        settle();

        // Length above the maximum clamps to the full ring.
        program_reg(REG_WINDOW_LEN, 32'd100);
        send_bias(32'h0000_0001);
        send_bias(32'hFFFF_FFFF);
        send_bias(32'h1234_5678);
        settle();
        settings_used += 4;

        for (int i = 0; i < 9; i++) begin
            if (i < 3) begin
                send_idle = 31;
                recv_idle = 51;
            end else if (i < 6) begin
                send_idle = 51;
                recv_idle = 31;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            w = (i == 7) ? $urandom_range(LEN_MIN, WINDOW_MAX) : phase_win[i];
            t = (i >= 7) ? $urandom_range(0, 65536) : phase_thr[i];
            program_reg(REG_WINDOW_LEN, w);
            program_reg(REG_THRESHOLD, t);
            settings_used++;
            run_batch(160);
            settle();
        end

        sb.close_out();
        $display("sent %0d bias words and checked %0d result words over %0d register settings",
                 sb.noted, sb.checked, settings_used);
        $display("%0d result words were confluent and %0d carried a fire pulse",
                 sb.conf_words, sb.fires);
        if (sb.mismatches == 0) begin
            $display("[sliding_window_sign_confluence] OK");
        end else begin
            $display("[sliding_window_sign_confluence] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/swsc_pkg.sv
hw/rtl/swsc_ctrl.sv
hw/rtl/swsc_dp.sv
hw/rtl/sliding_window_sign_confluence.sv
sim/sliding_window_sign_confluence_test.sv
